// ===== rtl/core/dsws_pkg.sv =====
// ----------------------------------------------------------------------------
// dsws_pkg
// Shared types, constants and the control program of the window scheduler.
// ----------------------------------------------------------------------------
package dsws_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_AUDIO_RATE         = 3'd0,
    CFG_IMU_RATE           = 3'd1,
    CFG_IMU_WINDOW_TICKS   = 3'd2,
    CFG_IMU_STEP_TICKS     = 3'd3,
    CFG_AUDIO_WINDOW_TICKS = 3'd4,
    CFG_AUDIO_STEP_TICKS   = 3'd5,
    CFG_DEADLINE_TICKS     = 3'd6,
    CFG_MAX_AUDIO_WINDOWS  = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RateW    = 15;
  localparam int unsigned LenW     = 20;
  localparam int unsigned TickW    = 32;
  localparam int unsigned RunW     = 4;

  // register reset values
  localparam logic [RateW-1:0] AudioRateRst        = 15'd16000;
  localparam logic [RateW-1:0] ImuRateRst          = 15'd100;
  localparam logic [LenW-1:0]  ImuWindowTicksRst   = 20'd16000;
  localparam logic [LenW-1:0]  ImuStepTicksRst     = 20'd8000;
  localparam logic [LenW-1:0]  AudioWindowTicksRst = 20'd8000;
  localparam logic [LenW-1:0]  AudioStepTicksRst   = 20'd4000;
  localparam logic [TickW-1:0] DeadlineTicksRst    = 32'd24000;
  localparam logic [RunW-1:0]  MaxAudioWindowsRst  = 4'd4;

  // divider geometry: product of tick and rate, two quotient bits a cycle
  localparam int unsigned ProdW    = TickW + RateW;
  localparam int unsigned DivW     = 48;
  localparam int unsigned DivRadix = 2;
  localparam int unsigned DivSteps = DivW / DivRadix;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // micro operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_TSR,
    OP_UPD,
    OP_REP,
    OP_MUL,
    OP_DLOAD,
    OP_DIV,
    OP_EMIT
  } uop_e;

  // jump conditions: jump to target while true, else fall through
  typedef enum logic [1:0] {
    CND_NEVER,
    CND_NO_REQ,
    CND_DIV_BUSY,
    CND_OUT_BUSY
  } cond_e;

  localparam int unsigned PcW = 3;

  typedef struct packed {
    uop_e           op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  // divider commands
  typedef struct packed {
    logic load;
    logic step;
  } div_cmd_t;

  // control store
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      3'd0:    w = '{op: OP_WAIT,  cond: CND_NO_REQ,   target: 3'd0};
      3'd1:    w = '{op: OP_TSR,   cond: CND_NEVER,    target: 3'd0};
      3'd2:    w = '{op: OP_UPD,   cond: CND_NEVER,    target: 3'd0};
      3'd3:    w = '{op: OP_REP,   cond: CND_NEVER,    target: 3'd0};
      3'd4:    w = '{op: OP_MUL,   cond: CND_NEVER,    target: 3'd0};
      3'd5:    w = '{op: OP_DLOAD, cond: CND_NEVER,    target: 3'd0};
      3'd6:    w = '{op: OP_DIV,   cond: CND_DIV_BUSY, target: 3'd6};
      default: w = '{op: OP_EMIT,  cond: CND_OUT_BUSY, target: 3'd7};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/dsws_div.sv =====
// ----------------------------------------------------------------------------
// dsws_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dsws_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dsws_pkg::div_cmd_t                  cmd_i,
  input  logic [dsws_pkg::DivW-1:0]           dividend_i,
  input  logic [dsws_pkg::RateW-1:0]          divisor_i,
  output logic [dsws_pkg::TickW-1:0]          quot_o,
  output logic                                last_o
);

  logic [dsws_pkg::DivW-1:0]    dvd_q, dvd_d;
  logic [dsws_pkg::RateW-1:0]   rem_q, rem_d;
  logic [dsws_pkg::DivCntW-1:0] cnt_q;

  // two compare-subtract steps; quotient bits shift in from the bottom.
  // a zero divisor yields an all-ones quotient
  always_comb begin
    logic [dsws_pkg::RateW:0] t;
    t     = '0;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < dsws_pkg::DivRadix; k++) begin
      t     = {rem_d, dvd_d[dsws_pkg::DivW-1]};
      dvd_d = {dvd_d[dsws_pkg::DivW-2:0], 1'b0};
      if (t >= {1'b0, divisor_i}) begin
        t        = t - {1'b0, divisor_i};
        dvd_d[0] = 1'b1;
      end
      rem_d = t[dsws_pkg::RateW-1:0];
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q[dsws_pkg::TickW-1:0];
  assign last_o = (cnt_q == dsws_pkg::DivCntW'(dsws_pkg::DivSteps - 1));

endmodule

// ===== rtl/core/dual_sensor_window_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// dual_sensor_window_scheduler_top
// Duty-cycling window scheduler for a motion / audio cough detector.
// ----------------------------------------------------------------------------
// Usage:
//   input channel carries one classifier verdict per window (cough_detected_i)
//   with in_valid_i / in_stall_o; the output channel carries the schedule for
//   the next window with out_valid_o / out_stall_i. a request moves when valid
//   is high and stall is low.
//   configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; the user must write them only while the block is idle, as
//   the block itself does not enforce it; writes take effect at once.
//   a small microprogram steps a shared datapath: accept, time since report,
//   schedule update, report check, multiply, divider load, 24 divider
//   iterations at two quotient bits each, and result load. the block takes
//   no new verdict while one is in progress; the next verdict can be taken
//   in the cycle after the result is loaded.
//   a finished result waits in the output register while the next verdict is
//   taken; if the receiver still stalls when the next result is ready, the
//   program holds on its last step until the output register frees up.
//   reset puts the block in motion mode with all tick counters at zero and
//   the registers at their default values.
// ----------------------------------------------------------------------------
module dual_sensor_window_scheduler_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [dsws_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsws_pkg::CfgDataW-1:0] cfg_data_i,
  // verdict input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cough_detected_i,
  // schedule output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          next_mode_o,
  output logic [dsws_pkg::TickW-1:0]    next_start_tick_o,
  output logic [dsws_pkg::TickW-1:0]    next_sample_index_o,
  output logic                          report_due_o,
  output logic [dsws_pkg::TickW-1:0]    report_tick_o
);

  // configuration registers
  logic [dsws_pkg::RateW-1:0]  audio_rate_q, imu_rate_q;
  logic [dsws_pkg::LenW-1:0]   imu_win_q, imu_step_q, aud_win_q, aud_step_q;
  logic [dsws_pkg::TickW-1:0]  deadline_q;
  logic [dsws_pkg::RunW-1:0]   max_run_q;

  // scheduler state and datapath
  logic                        mode_q;
  logic [dsws_pkg::TickW-1:0]  ws_q, prev_q, lrt_q, acc_q;
  logic [dsws_pkg::RunW-1:0]   run_cnt_q;
  logic                        cough_q, due_q;
  logic [dsws_pkg::ProdW-1:0]  prod_q;

  // sequencer
  logic [dsws_pkg::PcW-1:0]    pc_q;
  dsws_pkg::uword_t            uw;
  logic                        jump;

  // output register
  logic                        out_valid_q, out_mode_q, out_due_q;
  logic [dsws_pkg::TickW-1:0]  out_start_q, out_index_q, out_rtick_q;

  // divider
  dsws_pkg::div_cmd_t          div_cmd;
  logic [dsws_pkg::TickW-1:0]  quot;
  logic                        div_last;

  logic                        in_acc, out_busy, emit;
  logic [dsws_pkg::LenW-1:0]   len_cur, inc;
  logic                        ws_add;
  logic [dsws_pkg::RunW-1:0]   run_inc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_rate_q <= dsws_pkg::AudioRateRst;
      imu_rate_q   <= dsws_pkg::ImuRateRst;
      imu_win_q    <= dsws_pkg::ImuWindowTicksRst;
      imu_step_q   <= dsws_pkg::ImuStepTicksRst;
      aud_win_q    <= dsws_pkg::AudioWindowTicksRst;
      aud_step_q   <= dsws_pkg::AudioStepTicksRst;
      deadline_q   <= dsws_pkg::DeadlineTicksRst;
      max_run_q    <= dsws_pkg::MaxAudioWindowsRst;
    end else if (cfg_we_i) begin
      unique case (dsws_pkg::cfg_idx_e'(cfg_idx_i))
        dsws_pkg::CFG_AUDIO_RATE:         audio_rate_q <= cfg_data_i[dsws_pkg::RateW-1:0];
        dsws_pkg::CFG_IMU_RATE:           imu_rate_q   <= cfg_data_i[dsws_pkg::RateW-1:0];
        dsws_pkg::CFG_IMU_WINDOW_TICKS:   imu_win_q    <= cfg_data_i[dsws_pkg::LenW-1:0];
        dsws_pkg::CFG_IMU_STEP_TICKS:     imu_step_q   <= cfg_data_i[dsws_pkg::LenW-1:0];
        dsws_pkg::CFG_AUDIO_WINDOW_TICKS: aud_win_q    <= cfg_data_i[dsws_pkg::LenW-1:0];
        dsws_pkg::CFG_AUDIO_STEP_TICKS:   aud_step_q   <= cfg_data_i[dsws_pkg::LenW-1:0];
        dsws_pkg::CFG_DEADLINE_TICKS:     deadline_q   <= cfg_data_i[dsws_pkg::TickW-1:0];
        dsws_pkg::CFG_MAX_AUDIO_WINDOWS:  max_run_q    <= cfg_data_i[dsws_pkg::RunW-1:0];
      endcase
    end
  end

  // control word and handshake terms
  assign uw         = dsws_pkg::ucode(pc_q);
  assign in_stall_o = (uw.op != dsws_pkg::OP_WAIT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit       = (uw.op == dsws_pkg::OP_EMIT) && !out_busy;

  // jump condition select
  always_comb begin
    unique case (uw.cond)
      dsws_pkg::CND_NEVER:    jump = 1'b0;
      dsws_pkg::CND_NO_REQ:   jump = !in_valid_i;
      dsws_pkg::CND_DIV_BUSY: jump = !div_last;
      dsws_pkg::CND_OUT_BUSY: jump = out_busy;
    endcase
  end

  // step counter; the last step wraps to the wait step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (jump) begin
      pc_q <= uw.target;
    end else begin
      pc_q <= pc_q + 1'b1;
    end
  end

  // window length of the current mode
  assign len_cur = mode_q ? aud_win_q : imu_win_q;
  assign run_inc = run_cnt_q + 1'b1;

  // start advance chosen by the schedule update
  always_comb begin
    ws_add = 1'b1;
    if (!mode_q) begin
      ws_add = !cough_q;
      inc    = imu_step_q;
    end else if (cough_q && (run_inc < max_run_q)) begin
      inc    = aud_step_q;
    end else begin
      inc    = aud_win_q;
    end
  end

  // scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      ws_q      <= '0;
      lrt_q     <= '0;
      run_cnt_q <= '0;
    end else begin
      if (uw.op == dsws_pkg::OP_UPD) begin
        if (ws_add) begin
          ws_q <= ws_q + {{(dsws_pkg::TickW-dsws_pkg::LenW){1'b0}}, inc};
        end
        if (!mode_q) begin
          mode_q <= cough_q;
        end else if (cough_q) begin
          if (run_inc >= max_run_q) begin
            run_cnt_q <= '0;
            mode_q    <= 1'b0;
          end else begin
            run_cnt_q <= run_inc;
          end
        end else begin
          mode_q <= 1'b0;
        end
      end
      // report tick uses the window length of the new mode
      if ((uw.op == dsws_pkg::OP_REP) && (acc_q >= deadline_q)) begin
        lrt_q <= prev_q + {{(dsws_pkg::TickW-dsws_pkg::LenW){1'b0}}, len_cur};
      end
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      dsws_pkg::OP_WAIT: begin
        if (in_acc) cough_q <= cough_detected_i;
      end
      dsws_pkg::OP_TSR: begin
        acc_q  <= ws_q + {{(dsws_pkg::TickW-dsws_pkg::LenW){1'b0}}, len_cur} - lrt_q;
        prev_q <= ws_q;
      end
      dsws_pkg::OP_REP: begin
        due_q <= (acc_q >= deadline_q);
      end
      dsws_pkg::OP_MUL: begin
        prod_q <= dsws_pkg::ProdW'(ws_q) * dsws_pkg::ProdW'(imu_rate_q);
      end
      default: begin
      end
    endcase
  end

  // divider commands
  assign div_cmd.load = (uw.op == dsws_pkg::OP_DLOAD);
  assign div_cmd.step = (uw.op == dsws_pkg::OP_DIV);

  dsws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i ({{(dsws_pkg::DivW-dsws_pkg::ProdW){1'b0}}, prod_q}),
    .divisor_i  (audio_rate_q),
    .quot_o     (quot),
    .last_o     (div_last)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_mode_q  <= mode_q;
      out_start_q <= ws_q;
      out_index_q <= mode_q ? ws_q : quot;
      out_due_q   <= due_q;
      out_rtick_q <= lrt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign next_mode_o         = out_mode_q;
  assign next_start_tick_o   = out_start_q;
  assign next_sample_index_o = out_index_q;
  assign report_due_o        = out_due_q;
  assign report_tick_o       = out_rtick_q;

  // a new result only appears from the load step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(uw.op == dsws_pkg::OP_EMIT))
    else $error("output valid rose outside the load step");

  // a blocked load step holds the program
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == dsws_pkg::OP_EMIT && out_busy) |=> (uw.op == dsws_pkg::OP_EMIT))
    else $error("program left the load step while output busy");

  // divider loop stays until its last iteration
  a_div_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == dsws_pkg::OP_DIV && !div_last) |=> (uw.op == dsws_pkg::OP_DIV))
    else $error("divider loop exited early");

  // a cough in motion mode switches to audio and keeps the start
  a_to_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == dsws_pkg::OP_UPD && !mode_q && cough_q) |=> (mode_q && $stable(ws_q)))
    else $error("motion cough did not switch to audio in place");

endmodule
